// File: src/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Shared constants, codes and control types of the sorted list table.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STAT_W   = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 3'd0,
    ST_ABSENT = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_FULL   = 3'd3,
    ST_ENTRY  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_PUT,
    S_DEL_SRCH,
    S_DEL_SHIFT,
    S_DUMP,
    S_RESP
  } state_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_LAST,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  typedef enum logic [1:0] {
    WA_PTR,
    WA_PTR_PLUS,
    WA_PTR_MINUS
  } wr_addr_e;

  typedef struct packed {
    logic     load_value;
    ptr_op_e  ptr_op;
    logic     wr_en;
    wr_addr_e wr_addr;
    logic     wr_from_rd;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     out_load;
    status_e  out_status;
    logic     out_from_rd;
    logic     out_last;
  } slt_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic val_less;
    logic val_equal;
    logic ptr_zero;
    logic ptr_more;
    logic out_free;
  } slt_stat_t;

endpackage

// File: src/slt_if.sv
// ----------------------------------------------------------------------------
// slt_cmd_if / slt_rsp_if
// Valid/ready channels for commands into and results out of the table.
// ----------------------------------------------------------------------------
interface slt_cmd_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic signed [31:0]   value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface slt_rsp_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic signed [31:0]   entry_value;
  logic                 last;

  modport source (output valid, output status, output entry_value, output last, input ready);
  modport sink   (input valid, input status, input entry_value, input last, output ready);
endinterface

// File: src/slt_datapath.sv
// ----------------------------------------------------------------------------
// slt_datapath
// Entry memory, entry count, walk pointer, command value and result register.
// ----------------------------------------------------------------------------
module slt_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  slt_pkg::slt_cmd_t        cmd_i,
  output slt_pkg::slt_stat_t       stat_o,
  input  logic signed [31:0]       value_i,
  input  logic                     rsp_ready_i,
  output logic                     rsp_valid_o,
  output logic [2:0]               rsp_status_o,
  output logic signed [31:0]       rsp_entry_o,
  output logic                     rsp_last_o
);
  import slt_pkg::*;

  logic [DATA_W-1:0]        mem_q [CAPACITY];
  logic signed [DATA_W-1:0] rd_q;
  logic signed [DATA_W-1:0] value_q;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [IDX_W-1:0]         ptr_q, ptr_d;
  logic [IDX_W-1:0]         wr_addr;
  logic [DATA_W-1:0]        wr_data;
  logic                     out_valid_q, out_valid_d;
  logic [STAT_W-1:0]        out_status_q;
  logic signed [DATA_W-1:0] out_entry_q;
  logic                     out_last_q;
  logic                     out_free;

  always_comb begin
    unique case (cmd_i.ptr_op)
      PTR_HOLD: ptr_d = ptr_q;
      PTR_ZERO: ptr_d = '0;
      PTR_LAST: ptr_d = IDX_W'(cnt_q - CNT_W'(1));
      PTR_INC:  ptr_d = ptr_q + IDX_W'(1);
      PTR_DEC:  ptr_d = ptr_q - IDX_W'(1);
      default:  ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_addr)
      WA_PTR:       wr_addr = ptr_q;
      WA_PTR_PLUS:  wr_addr = ptr_q + IDX_W'(1);
      WA_PTR_MINUS: wr_addr = ptr_q - IDX_W'(1);
      default:      wr_addr = ptr_q;
    endcase
  end

  assign wr_data = cmd_i.wr_from_rd ? rd_q : value_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[ptr_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_value) begin
      value_q <= value_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_free    = !out_valid_q || rsp_ready_i;
  assign out_valid_d = cmd_i.out_load || (out_valid_q && !rsp_ready_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_entry_q  <= cmd_i.out_from_rd ? rd_q : '0;
      out_last_q   <= cmd_i.out_last;
    end
  end

  assign stat_o.cnt_zero  = (cnt_q == '0);
  assign stat_o.cnt_full  = (cnt_q == CNT_W'(CAPACITY));
  assign stat_o.val_less  = (value_q < rd_q);
  assign stat_o.val_equal = (value_q == rd_q);
  assign stat_o.ptr_zero  = (ptr_q == '0);
  assign stat_o.ptr_more  = ((CNT_W'(ptr_q) + CNT_W'(1)) < cnt_q);
  assign stat_o.out_free  = out_free;

  assign rsp_valid_o  = out_valid_q;
  assign rsp_status_o = out_status_q;
  assign rsp_entry_o  = out_entry_q;
  assign rsp_last_o   = out_last_q;

endmodule

// File: src/slt_ctrl.sv
// ----------------------------------------------------------------------------
// slt_ctrl
// Command sequencer: search, shift and dump walks over the entry memory.
// ----------------------------------------------------------------------------
module slt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  logic [1:0]           cmd_opcode_i,
  input  slt_pkg::slt_stat_t   stat_i,
  output slt_pkg::slt_cmd_t    cmd_o
);
  import slt_pkg::*;

  state_e  state_q, state_d;
  status_e res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= ST_DONE;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    cmd_ready_o = 1'b0;
    cmd_o       = '{load_value: 1'b0, ptr_op: PTR_HOLD, wr_en: 1'b0, wr_addr: WA_PTR,
                    wr_from_rd: 1'b0, cnt_inc: 1'b0, cnt_dec: 1'b0, out_load: 1'b0,
                    out_status: ST_DONE, out_from_rd: 1'b0, out_last: 1'b1};

    unique case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_o.load_value = 1'b1;
          unique case (cmd_opcode_i)
            OP_INSERT: begin
              if (stat_i.cnt_full) begin
                res_d   = ST_FULL;
                state_d = S_RESP;
              end else if (stat_i.cnt_zero) begin
                cmd_o.ptr_op = PTR_ZERO;
                state_d      = S_INS_PUT;
              end else begin
                cmd_o.ptr_op = PTR_LAST;
                state_d      = S_INS;
              end
            end
            OP_DELETE: begin
              if (stat_i.cnt_zero) begin
                res_d   = ST_EMPTY;
                state_d = S_RESP;
              end else begin
                cmd_o.ptr_op = PTR_ZERO;
                state_d      = S_DEL_SRCH;
              end
            end
            OP_DUMP: begin
              if (stat_i.cnt_zero) begin
                res_d   = ST_EMPTY;
                state_d = S_RESP;
              end else begin
                cmd_o.ptr_op = PTR_ZERO;
                state_d      = S_DUMP;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_INS: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = WA_PTR_PLUS;
        if (stat_i.val_less) begin
          cmd_o.wr_from_rd = 1'b1;
          if (stat_i.ptr_zero) begin
            state_d = S_INS_PUT;
          end else begin
            cmd_o.ptr_op = PTR_DEC;
          end
        end else begin
          cmd_o.cnt_inc = 1'b1;
          res_d         = ST_DONE;
          state_d       = S_RESP;
        end
      end

      S_INS_PUT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = WA_PTR;
        cmd_o.cnt_inc = 1'b1;
        res_d         = ST_DONE;
        state_d       = S_RESP;
      end

      S_DEL_SRCH: begin
        priority if (stat_i.val_equal && stat_i.ptr_more) begin
          cmd_o.ptr_op = PTR_INC;
          state_d      = S_DEL_SHIFT;
        end else if (stat_i.val_equal) begin
          cmd_o.cnt_dec = 1'b1;
          res_d         = ST_DONE;
          state_d       = S_RESP;
        end else if (stat_i.ptr_more) begin
          cmd_o.ptr_op = PTR_INC;
        end else begin
          res_d   = ST_ABSENT;
          state_d = S_RESP;
        end
      end

      S_DEL_SHIFT: begin
        cmd_o.wr_en      = 1'b1;
        cmd_o.wr_addr    = WA_PTR_MINUS;
        cmd_o.wr_from_rd = 1'b1;
        if (stat_i.ptr_more) begin
          cmd_o.ptr_op = PTR_INC;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          res_d         = ST_DONE;
          state_d       = S_RESP;
        end
      end

      S_DUMP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load    = 1'b1;
          cmd_o.out_status  = ST_ENTRY;
          cmd_o.out_from_rd = 1'b1;
          cmd_o.out_last    = !stat_i.ptr_more;
          if (stat_i.ptr_more) begin
            cmd_o.ptr_op = PTR_INC;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = res_q;
          state_d          = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: src/sorted_list_table_core.sv
// ----------------------------------------------------------------------------
// sorted_list_table_core
// Bounded table of signed 32-bit values kept in ascending order.
// ----------------------------------------------------------------------------
// cmd_i carries one command per transfer: insert, delete or dump with a
// signed value. rsp_o returns results; last marks the final result of a
// command. Insert, delete and every error give exactly one result; dump
// gives one result per entry, or a single empty status on an empty table.
// Commands are taken one at a time from the idle state; a new command is
// taken while the previous result still waits in the output register.
// Insert moves each entry larger than the new value up one place, with one
// memory read and one write per cycle on the entry memory. Delete searches
// from the first entry and moves every entry after the match down one place.
// Dump gives one entry per cycle while the receiver keeps ready. Opcode 3 is
// dropped with no result.
// Reset empties the table (count to zero) and drops any pending result; the
// memory itself is not cleared. A stalled receiver holds the result
// register and halts a dump walk until the transfer completes.
// ----------------------------------------------------------------------------
module sorted_list_table_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  slt_cmd_if.sink   cmd_i,
  slt_rsp_if.source rsp_o
);
  import slt_pkg::*;

  slt_cmd_t  ctl_cmd;
  slt_stat_t dp_stat;

  slt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_i.valid),
    .cmd_ready_o  (cmd_i.ready),
    .cmd_opcode_i (cmd_i.opcode),
    .stat_i       (dp_stat),
    .cmd_o        (ctl_cmd)
  );

  slt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctl_cmd),
    .stat_o       (dp_stat),
    .value_i      (cmd_i.value),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_status_o (rsp_o.status),
    .rsp_entry_o  (rsp_o.entry_value),
    .rsp_last_o   (rsp_o.last)
  );

endmodule

// File: src/slt_checker.sv
// ----------------------------------------------------------------------------
// slt_checker
// Port-level checks on the result channel of the sorted list table.
// ----------------------------------------------------------------------------
module slt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic [2:0]         rsp_status_i,
  input logic signed [31:0] rsp_entry_i,
  input logic               rsp_last_i
);
  import slt_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped before transfer");

  a_status_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ST_ENTRY) |-> (rsp_entry_i == '0))
    else $error("non-entry result carries a value");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ST_ENTRY) |-> rsp_last_i)
    else $error("single result without last");

  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !rsp_valid_i)
    else $error("result shown straight after reset");

endmodule

bind sorted_list_table_core slt_checker u_slt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_entry_i  (rsp_o.entry_value),
  .rsp_last_i   (rsp_o.last)
);

// File: bench/tb_sorted_list_table_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_list_table_core
// Self-checking bench for the sorted list table.
// ----------------------------------------------------------------------------
// Commands go in as valid/ready transfers. A behavioural copy of the table
// works out every expected result. A checker compares each result transfer
// with the oldest pending expectation. Directed cases come first: the empty
// table, the extreme values, duplicates, an absent value and the unused
// opcode. Random traffic then sweeps the fill level between empty and full
// under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_sorted_list_table_core;
  import slt_pkg::*;

  localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
  localparam logic signed [31:0] VAL_MIN    = 32'h8000_0000;
  localparam logic signed [31:0] VAL_MAX    = 32'h7fff_ffff;
  localparam int                 STALL_LIMIT = 4000;
  localparam int                 TAIL_CYCLES = 60;

  typedef struct {
    status_e     status;
    logic [31:0] entry_value;
    logic        last;
  } table_result_t;

  logic clk;
  logic rst_n;

  slt_cmd_if cmd_if ();
  slt_rsp_if rsp_if ();

  sorted_list_table_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  logic signed [31:0] table_model[$];
  table_result_t      pending_results[$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int mismatch_count  = 0;
  int idle_cycles     = 0;
  int results_checked = 0;
  int n_insert = 0, n_delete = 0, n_dump = 0, n_dropped = 0;
  int n_full = 0, n_absent = 0, n_empty = 0, max_fill = 0;
  bit growing = 1'b1;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d entry_value %0d last %0b",
               rsp_if.status, $signed(rsp_if.entry_value), rsp_if.last);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          mismatch_count++;
        end
        if (rsp_if.entry_value !== want.entry_value) begin
          $error("entry_value: expected %0d, got %0d",
                 $signed(want.entry_value), $signed(rsp_if.entry_value));
          mismatch_count++;
        end
        if (rsp_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, rsp_if.last);
          mismatch_count++;
        end
      end
    end
  end

  function automatic void queue_result(status_e st, logic [31:0] v, logic lst);
    table_result_t r;
    r.status      = st;
    r.entry_value = v;
    r.last        = lst;
    pending_results.push_back(r);
  endfunction

  task automatic apply_table_command(input logic [OP_W-1:0] op,
                                     input logic signed [31:0] val);
    int pos;
    case (op)
      OP_INSERT: begin
        n_insert++;
        if (table_model.size() >= CAPACITY) begin
          n_full++;
          queue_result(ST_FULL, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < table_model.size() && !(val < table_model[pos])) pos++;
          table_model.insert(pos, val);
          if (table_model.size() > max_fill) max_fill = table_model.size();
          queue_result(ST_DONE, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        n_delete++;
        if (table_model.size() == 0) begin
          n_empty++;
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < table_model.size() && table_model[pos] != val) pos++;
          if (pos >= table_model.size()) begin
            n_absent++;
            queue_result(ST_ABSENT, '0, 1'b1);
          end else begin
            table_model.delete(pos);
            queue_result(ST_DONE, '0, 1'b1);
          end
        end
      end
      OP_DUMP: begin
        n_dump++;
        if (table_model.size() == 0) begin
          n_empty++;
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          foreach (table_model[i])
            queue_result(ST_ENTRY, table_model[i], i == table_model.size() - 1);
        end
      end
      default: n_dropped++;
    endcase
  endtask

  task automatic send_command(input logic [OP_W-1:0] op, input logic signed [31:0] val);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid  <= 1'b1;
    cmd_if.opcode <= op;
    cmd_if.value  <= val;
    do @(posedge clk); while (!cmd_if.ready);
    apply_table_command(op, val);
  endtask

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value(bit for_delete);
    if (for_delete && table_model.size() > 0 && $urandom_range(0, 99) < 75)
      return table_model[$urandom_range(0, table_model.size() - 1)];
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3, 4: return $signed($urandom_range(0, 15)) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_table();
    send_command(OP_DUMP, $urandom);
    send_command(OP_DELETE, 0);
  endtask

  task automatic test_ordering_extremes();
    send_command(OP_INSERT, 5);
    send_command(OP_DELETE, 7);
    send_command(OP_DUMP, 0);
    send_command(OP_INSERT, VAL_MIN);
    send_command(OP_INSERT, VAL_MAX);
    send_command(OP_INSERT, 0);
    send_command(OP_INSERT, -1);
    send_command(OP_INSERT, 5);
    send_command(OP_INSERT, VAL_MAX);
    send_command(OP_DUMP, VAL_MAX);
  endtask

  task automatic test_delete_and_ignored();
    send_command(OP_DELETE, 5);
    send_command(OP_DELETE, VAL_MIN);
    send_command(OP_DELETE, VAL_MAX);
    send_command(OP_DELETE, 9);
    send_command(OP_UNUSED, VAL_MIN);
    send_command(OP_UNUSED, VAL_MAX);
    send_command(OP_DUMP, 0);
    send_command(OP_DELETE, 1);
  endtask

  // Sweep the fill level: mostly inserts until full, mostly deletes until empty.
  task automatic test_random_traffic(input int n_items, input int send_pct,
                                     input int stall_pct);
    int sent, r;
    sender_idle_pct = send_pct;
    recv_stall_pct  = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      if (growing && table_model.size() >= CAPACITY && $urandom_range(0, 3) == 0)
        growing = 1'b0;
      else if (!growing && table_model.size() == 0 && $urandom_range(0, 2) == 0)
        growing = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_command(OP_UNUSED, $urandom);
      end else begin
        sent++;
        if (r < 12)
          send_command(OP_DUMP, $urandom);
        else if ((r < 75) == growing)
          send_command(OP_INSERT, pick_value(1'b0));
        else
          send_command(OP_DELETE, pick_value(1'b1));
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    cmd_if.valid  <= 1'b0;
    cmd_if.opcode <= OP_INSERT;
    cmd_if.value  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_ordering_extremes();
    test_delete_and_ignored();
    wait_drained();

    test_random_traffic(80, 0, 0);
    wait_drained();
    test_random_traffic(80, 78, 0);
    test_random_traffic(80, 0, 78);
    wait_drained();
    test_random_traffic(80, 30, 30);
    wait_drained();

    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("commands: %0d insert, %0d delete, %0d dump, %0d dropped; %0d results checked",
             n_insert, n_delete, n_dump, n_dropped, results_checked);
    $display("peak fill %0d of %0d; %0d full rejects, %0d absent, %0d empty-table results",
             max_fill, CAPACITY, n_full, n_absent, n_empty);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/slt_pkg.sv
src/slt_if.sv
src/slt_datapath.sv
src/slt_ctrl.sv
src/sorted_list_table_core.sv
src/slt_checker.sv
bench/tb_sorted_list_table_core.sv
